// ===== hw/rtl/led_blink_pattern_engine_macros.svh =====
// led blink pattern engine: assertion macros
// used by the top level only, no other dependencies
`ifndef LED_BLINK_PATTERN_ENGINE_MACROS_SVH
`define LED_BLINK_PATTERN_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpe same-cycle check failed");

// next-cycle implication, checked outside reset
`define LBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpe next-cycle check failed");

`endif

// ===== hw/rtl/lbpe_pkg.sv =====
// led blink pattern engine: shared types and constants
// no dependencies; used by every rtl module of the block
package lbpe_pkg;

    // command codes on the func field
    localparam logic [1:0] FUNC_SET     = 2'd0;
    localparam logic [1:0] FUNC_RESTORE = 2'd1;
    localparam logic [1:0] FUNC_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CONFIGURED  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd1;

    // widths of the pin word, the led index field and the on and off times
    localparam int PIN_W   = 8;
    localparam int LIDX_W  = 3;
    localparam int ON_W    = 16;
    localparam int OFF_W   = 17;

    // operation applied by the shared update unit
    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_RESTORE
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_CMD,
        ST_FINISH
    } t_state;

    // state kept for one led
    typedef struct packed {
        logic              lit;
        logic              phase;
        logic [ON_W-1:0]   cur_on;
        logic [OFF_W-1:0]  cur_off;
        logic [ON_W-1:0]   sav_on;
        logic [OFF_W-1:0]  sav_off;
        logic              prio;
        logic              made;
        logic              running;
        logic [ON_W-1:0]   count;
    } t_slot;

    // command payload held for the duration of an item
    typedef struct packed {
        logic [ON_W-1:0]   on_time;
        logic [OFF_W-1:0]  off_time;
        logic              push;
    } t_cmd;

endpackage

// ===== hw/rtl/lbpe_unit.sv =====
// led blink pattern engine: shared update unit for one led slot
// applies a tick, a set or a restore; depends on lbpe_pkg
module lbpe_unit (
    input  lbpe_pkg::t_op   i_op,
    input  lbpe_pkg::t_slot i_slot,
    input  lbpe_pkg::t_cmd  i_cmd,
    output lbpe_pkg::t_slot o_slot
);

    logic [lbpe_pkg::ON_W-1:0]  ap_on;
    logic [lbpe_pkg::OFF_W-1:0] ap_off;
    logic                       ap_push;

    // pattern source: command payload, or saved times for a restore
    always_comb begin
        if (i_op == lbpe_pkg::OP_RESTORE) begin
            ap_on   = i_slot.sav_on;
            ap_off  = i_slot.sav_off;
            ap_push = 1'b1;
        end else begin
            ap_on   = i_cmd.on_time;
            ap_off  = i_cmd.off_time;
            ap_push = i_cmd.push;
        end
    end

    // next slot state
    always_comb begin
        o_slot = i_slot;
        unique case (i_op)
            lbpe_pkg::OP_TICK: begin
                if (i_slot.running) begin
                    if (i_slot.count > 16'd1) begin
                        o_slot.count = i_slot.count - 16'd1;
                    end else begin
                        o_slot.phase = ~i_slot.phase;
                        o_slot.lit   = ~i_slot.phase;
                        // entering dark with a one-shot off time stops the timer
                        if (i_slot.phase && i_slot.cur_off[lbpe_pkg::OFF_W-1]) begin
                            o_slot.running = 1'b0;
                            o_slot.count   = '0;
                        end else if (i_slot.phase) begin
                            o_slot.count = i_slot.cur_off[lbpe_pkg::ON_W-1:0];
                        end else begin
                            o_slot.count = i_slot.cur_on;
                        end
                    end
                end
            end
            lbpe_pkg::OP_SET, lbpe_pkg::OP_RESTORE: begin
                if (i_slot.made && !ap_push && i_slot.prio) begin
                    // priority held: only the saved pattern changes
                    o_slot.sav_on  = ap_on;
                    o_slot.sav_off = ap_off;
                end else begin
                    if (i_slot.made) begin
                        o_slot.running = 1'b0;
                    end
                    if (!i_slot.prio) begin
                        o_slot.sav_on  = i_slot.cur_on;
                        o_slot.sav_off = i_slot.cur_off;
                        o_slot.prio    = ap_push;
                    end
                    o_slot.cur_on  = ap_on;
                    o_slot.cur_off = ap_off;
                    if (ap_on == '0) begin
                        o_slot.lit = 1'b0;
                    end else if (ap_off == '0) begin
                        o_slot.lit = 1'b1;
                    end else begin
                        o_slot.made    = 1'b1;
                        o_slot.phase   = 1'b1;
                        o_slot.lit     = 1'b1;
                        o_slot.count   = ap_on;
                        o_slot.running = 1'b1;
                    end
                end
                if (i_op == lbpe_pkg::OP_RESTORE) begin
                    o_slot.prio = 1'b0;
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lbpe_seq.sv =====
// led blink pattern engine: item sequencer
// walks the led slots for a tick and touches one slot for a command; depends on lbpe_pkg
module lbpe_seq #(
    parameter int NUM_LED = 8,
    parameter int IDX_W   = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [1:0]                    i_func,
    input  logic [lbpe_pkg::LIDX_W-1:0]   i_led_index,
    input  logic                          i_cmd_ok,
    output logic                          busy,
    output lbpe_pkg::t_op                 o_op,
    output logic [IDX_W-1:0]              o_idx,
    output logic                          o_wr_en,
    output logic                          o_finish,
    output logic                          o_acc
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LED - 1);

    lbpe_pkg::t_state r_state, n_state;
    lbpe_pkg::t_op    r_op, n_op;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_acc, n_acc;

    // next state and captured control
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_idx   = r_idx;
        n_acc   = r_acc;
        unique case (r_state)
            lbpe_pkg::ST_IDLE: begin
                if (start) begin
                    n_idx = '0;
                    if (i_func == lbpe_pkg::FUNC_TICK) begin
                        n_state = lbpe_pkg::ST_TICK;
                        n_op    = lbpe_pkg::OP_TICK;
                        n_acc   = 1'b1;
                    end else if (i_cmd_ok) begin
                        n_state = lbpe_pkg::ST_CMD;
                        n_op    = (i_func == lbpe_pkg::FUNC_RESTORE) ?
                                  lbpe_pkg::OP_RESTORE : lbpe_pkg::OP_SET;
                        n_idx   = i_led_index[IDX_W-1:0];
                        n_acc   = 1'b1;
                    end else begin
                        n_state = lbpe_pkg::ST_FINISH;
                        n_acc   = 1'b0;
                    end
                end
            end
            lbpe_pkg::ST_TICK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = lbpe_pkg::ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lbpe_pkg::ST_CMD: begin
                n_state = lbpe_pkg::ST_FINISH;
            end
            lbpe_pkg::ST_FINISH: begin
                n_state = lbpe_pkg::ST_IDLE;
            end
            default: begin
                n_state = lbpe_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        busy     = 1'b1;
        o_wr_en  = 1'b0;
        o_finish = 1'b0;
        unique case (r_state)
            lbpe_pkg::ST_IDLE:   busy     = 1'b0;
            lbpe_pkg::ST_TICK:   o_wr_en  = 1'b1;
            lbpe_pkg::ST_CMD:    o_wr_en  = 1'b1;
            lbpe_pkg::ST_FINISH: o_finish = 1'b1;
            default:             busy     = 1'b1;
        endcase
    end

    assign o_op  = r_op;
    assign o_idx = r_idx;
    assign o_acc = r_acc;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbpe_pkg::ST_IDLE;
            r_op    <= lbpe_pkg::OP_TICK;
            r_idx   <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== hw/rtl/led_blink_pattern_engine.sv =====
// led blink pattern engine: top level with led slot registers and result port
// depends on lbpe_pkg, lbpe_seq, lbpe_unit and led_blink_pattern_engine_macros.svh
//
// Usage: an item (func, led_index, on_time, off_time, push_request) is taken at
// a rising edge with start high and busy low. Each item yields one result,
// shown on o_accepted and o_pin_levels for a single cycle with o_valid high;
// the receiver cannot stall it.
// Sequencing: a tick steps one shared update unit over the led slots, one slot
// per cycle, then enters a finish state; a set or restore touches one slot and
// a rejected command goes straight to the finish state. The result is registered
// from the finish state. busy falls in the cycle the result is shown, so the
// next item can follow then.
// Only the first eight leds are addressable; LED_COUNT above eight adds none.
// Configuration: i_cfg_valid/o_cfg_ready write configured_mask (index 0) or
// active_high_mask (index 1); other indexes are ignored. Writes are always taken.
// The user must make them only while the block is idle; the block does not enforce it.
// Reset: synchronous, active low; all leds dark, no timers, masks zero.
`include "led_blink_pattern_engine_macros.svh"

module led_blink_pattern_engine #(
    parameter int LED_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_func,
    input  logic [lbpe_pkg::LIDX_W-1:0]         i_led_index,
    input  logic [lbpe_pkg::ON_W-1:0]           i_on_time,
    input  logic signed [lbpe_pkg::OFF_W-1:0]   i_off_time,
    input  logic                                i_push_request,
    // result channel
    output logic                                o_valid,
    output logic                                o_accepted,
    output logic [lbpe_pkg::PIN_W-1:0]          o_pin_levels,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [lbpe_pkg::PIN_W-1:0]          i_cfg_data
);

    localparam int NUM_LED = (LED_COUNT < lbpe_pkg::PIN_W) ? LED_COUNT : lbpe_pkg::PIN_W;
    localparam int IDX_W   = (NUM_LED > 1) ? $clog2(NUM_LED) : 1;
    localparam logic [lbpe_pkg::PIN_W-1:0] LED_MASK =
        lbpe_pkg::PIN_W'((1 << NUM_LED) - 1);

    logic [lbpe_pkg::PIN_W-1:0] r_cfg_mask;
    logic [lbpe_pkg::PIN_W-1:0] r_pol_mask;
    lbpe_pkg::t_slot            r_slot [NUM_LED];
    lbpe_pkg::t_cmd             r_cmd;
    logic                       r_valid;
    logic                       r_acc;
    logic [lbpe_pkg::PIN_W-1:0] r_pins;

    logic                       cmd_ok;
    logic                       take;
    lbpe_pkg::t_op              seq_op;
    logic [IDX_W-1:0]           seq_idx;
    logic                       seq_wr_en;
    logic                       seq_finish;
    logic                       seq_acc;
    lbpe_pkg::t_slot            unit_out;
    logic [lbpe_pkg::PIN_W-1:0] lit_word;
    logic [lbpe_pkg::PIN_W-1:0] pin_word;

    assign take        = start && !busy;
    assign o_cfg_ready = 1'b1;

    // command is applied only to an existing, configured led
    assign cmd_ok = (i_func == lbpe_pkg::FUNC_SET || i_func == lbpe_pkg::FUNC_RESTORE) &&
                    ({1'b0, i_led_index} < 4'(NUM_LED)) && r_cfg_mask[i_led_index];

    lbpe_seq #(
        .NUM_LED (NUM_LED),
        .IDX_W   (IDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_func      (i_func),
        .i_led_index (i_led_index),
        .i_cmd_ok    (cmd_ok),
        .busy        (busy),
        .o_op        (seq_op),
        .o_idx       (seq_idx),
        .o_wr_en     (seq_wr_en),
        .o_finish    (seq_finish),
        .o_acc       (seq_acc)
    );

    lbpe_unit u_unit (
        .i_op   (seq_op),
        .i_slot (r_slot[seq_idx]),
        .i_cmd  (r_cmd),
        .o_slot (unit_out)
    );

    // pin word from the lit levels, polarity and configuration
    always_comb begin
        lit_word = '0;
        for (int i = 0; i < NUM_LED; i++) begin
            lit_word[i] = r_slot[i].lit;
        end
        pin_word = LED_MASK & r_cfg_mask & ~(lit_word ^ r_pol_mask);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mask <= '0;
            r_pol_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == lbpe_pkg::CFG_CONFIGURED) begin
                r_cfg_mask <= i_cfg_data;
            end else if (i_cfg_index == lbpe_pkg::CFG_ACTIVE_HIGH) begin
                r_pol_mask <= i_cfg_data;
            end
        end
    end

    // command payload capture on the start transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.on_time  <= i_on_time;
            r_cmd.off_time <= $unsigned(i_off_time);
            r_cmd.push     <= i_push_request;
        end
    end

    // led slot registers, written back by the shared unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LED; i++) begin
                r_slot[i] <= '0;
            end
        end else if (seq_wr_en) begin
            r_slot[seq_idx] <= unit_out;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= seq_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_finish) begin
            r_acc  <= seq_acc;
            r_pins <= pin_word;
        end
    end

    assign o_valid      = r_valid;
    assign o_accepted   = r_acc;
    assign o_pin_levels = r_pins;

    // checks on sequencing and the result strobe
    `LBPE_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, take, busy)
    `LBPE_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, seq_finish, o_valid && !busy)
    `LBPE_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    `LBPE_ASSERT_NOW(a_write_busy, i_clk, i_rst_n, seq_wr_en, busy && !seq_finish)

endmodule

// ===== tb/sv/lbpe_pin_checker.sv =====
// led blink pattern engine: checker that predicts and compares every result
// watches the item, result and register channels; depends on lbpe_pkg only
module lbpe_pin_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [1:0]                        i_func,
    input  logic [lbpe_pkg::LIDX_W-1:0]       i_led_index,
    input  logic [lbpe_pkg::ON_W-1:0]         i_on_time,
    input  logic [lbpe_pkg::OFF_W-1:0]        i_off_time,
    input  logic                              i_push_request,
    // result channel
    input  logic                              i_valid,
    input  logic                              i_accepted,
    input  logic [lbpe_pkg::PIN_W-1:0]        i_pin_levels,
    // register channel
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [lbpe_pkg::PIN_W-1:0]        i_cfg_data,
    // end of stimulus, flags results that never came
    input  logic                              i_run_done,
    output int                                o_pending,
    output int                                o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LED_NUM     = 8;
    localparam int PRINT_LIMIT = 200;

    typedef struct packed {
        logic                       accepted;
        logic [lbpe_pkg::PIN_W-1:0] pins;
    } t_pin_result;

    // predicted led state and register copies
    lbpe_pkg::t_slot            led_slot [LED_NUM];
    logic [lbpe_pkg::PIN_W-1:0] enabled_bits;
    logic [lbpe_pkg::PIN_W-1:0] high_lit_bits;
    t_pin_result                expected_pins [$];
    int                         outstanding = 0;
    int                         mismatch_total = 0;
    int                         printed = 0;
    logic                       leftover_done = 1'b0;

    assign o_pending    = outstanding;
    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        if (printed < PRINT_LIMIT)
            $display("%0t ns: wrong %s, expected 'h%0h, got 'h%0h", $time, what, want_v, got_v);
        printed++;
        mismatch_total++;
    endtask

    // set a pattern on one led, honouring the held priority pattern
    function automatic void load_pattern(input int i, input logic [lbpe_pkg::ON_W-1:0] on,
                                         input logic [lbpe_pkg::OFF_W-1:0] off,
                                         input logic push);
        if (led_slot[i].made) begin
            if (!push && led_slot[i].prio) begin
                led_slot[i].sav_on  = on;
                led_slot[i].sav_off = off;
                return;
            end
            led_slot[i].running = 1'b0;
        end
        if (!led_slot[i].prio) begin
            led_slot[i].sav_on  = led_slot[i].cur_on;
            led_slot[i].sav_off = led_slot[i].cur_off;
            led_slot[i].prio    = push;
        end
        led_slot[i].cur_on  = on;
        led_slot[i].cur_off = off;
        if (on == '0) begin
            led_slot[i].lit = 1'b0;
        end else if (off == '0) begin
            led_slot[i].lit = 1'b1;
        end else begin
            led_slot[i].made    = 1'b1;
            led_slot[i].phase   = 1'b1;
            led_slot[i].lit     = 1'b1;
            led_slot[i].count   = on;
            led_slot[i].running = 1'b1;
        end
    endfunction

    // one tick on one led timer
    function automatic void advance_timer(input int i);
        if (!led_slot[i].running)
            return;
        if (led_slot[i].count > 1) begin
            led_slot[i].count = led_slot[i].count - 1'b1;
            return;
        end
        led_slot[i].phase = ~led_slot[i].phase;
        led_slot[i].lit   = led_slot[i].phase;
        // negative off time: lit once, then dark for good
        if (!led_slot[i].phase && led_slot[i].cur_off[lbpe_pkg::OFF_W-1]) begin
            led_slot[i].running = 1'b0;
            led_slot[i].count   = '0;
            return;
        end
        led_slot[i].count = led_slot[i].phase ? led_slot[i].cur_on
                                              : led_slot[i].cur_off[lbpe_pkg::ON_W-1:0];
    endfunction

    // apply one item and work out the pin word it leaves behind
    function automatic t_pin_result predict_pins(input logic [1:0] func,
                                                 input logic [lbpe_pkg::LIDX_W-1:0] idx,
                                                 input logic [lbpe_pkg::ON_W-1:0] on,
                                                 input logic [lbpe_pkg::OFF_W-1:0] off,
                                                 input logic push);
        t_pin_result                r;
        logic [lbpe_pkg::ON_W-1:0]  keep_on;
        logic [lbpe_pkg::OFF_W-1:0] keep_off;
        r = '0;
        if (func == lbpe_pkg::FUNC_TICK) begin
            for (int i = 0; i < LED_NUM; i++)
                advance_timer(i);
            r.accepted = 1'b1;
        end else if ((func == lbpe_pkg::FUNC_SET || func == lbpe_pkg::FUNC_RESTORE) &&
                     enabled_bits[idx]) begin
            if (func == lbpe_pkg::FUNC_SET) begin
                load_pattern(int'(idx), on, off, push);
            end else begin
                keep_on  = led_slot[idx].sav_on;
                keep_off = led_slot[idx].sav_off;
                load_pattern(int'(idx), keep_on, keep_off, 1'b1);
                led_slot[idx].prio = 1'b0;
            end
            r.accepted = 1'b1;
        end
        // polarity per led, unconfigured pins low
        for (int i = 0; i < LED_NUM; i++)
            if (enabled_bits[i])
                r.pins[i] = led_slot[i].lit ? high_lit_bits[i] : ~high_lit_bits[i];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pin_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LED_NUM; i++)
                led_slot[i] = '0;
            enabled_bits  = '0;
            high_lit_bits = '0;
            expected_pins.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lbpe_pkg::CFG_CONFIGURED:  enabled_bits  = i_cfg_data;
                    lbpe_pkg::CFG_ACTIVE_HIGH: high_lit_bits = i_cfg_data;
                    default: ;
                endcase
            end
            // result compare against the oldest prediction
            if (i_valid) begin
                if (expected_pins.size() == 0) begin
                    report_mismatch("result, none outstanding", '0,
                                    {23'd0, i_accepted, i_pin_levels});
                end else begin
                    want = expected_pins.pop_front();
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted flag", 32'(want.accepted),
                                        32'(i_accepted));
                    if (i_pin_levels !== want.pins)
                        report_mismatch("pin levels", 32'(want.pins), 32'(i_pin_levels));
                end
            end
            // item transfer
            if (i_start && !i_busy)
                expected_pins.push_back(predict_pins(i_func, i_led_index, i_on_time,
                                                     i_off_time, i_push_request));
            if (i_run_done && !leftover_done) begin
                leftover_done = 1'b1;
                if (expected_pins.size() != 0)
                    report_mismatch("count of missing results", '0,
                                    32'(expected_pins.size()));
            end
        end
        outstanding = expected_pins.size();
    end

endmodule

// ===== tb/sv/tb_led_blink_pattern_engine.sv =====
// led blink pattern engine: testbench top with clock, reset, stimulus and verdict
// depends on lbpe_pkg, led_blink_pattern_engine and lbpe_pin_checker
module tb_led_blink_pattern_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [lbpe_pkg::OFF_W-1:0] OFF_ONCE     = 17'h1FFFF;
    localparam logic [lbpe_pkg::OFF_W-1:0] OFF_MOST_NEG = 17'h10000;
    localparam int PHASE_ITEMS   = 205;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic [1:0]                         i_func = '0;
    logic [lbpe_pkg::LIDX_W-1:0]        i_led_index = '0;
    logic [lbpe_pkg::ON_W-1:0]          i_on_time = '0;
    logic signed [lbpe_pkg::OFF_W-1:0]  i_off_time = '0;
    logic                               i_push_request = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [1:0]                         i_cfg_index = '0;
    logic [lbpe_pkg::PIN_W-1:0]         i_cfg_data = '0;
    logic                               run_done = 1'b0;
    logic                               busy;
    logic                               o_valid;
    logic                               o_accepted;
    logic [lbpe_pkg::PIN_W-1:0]         o_pin_levels;
    logic                               o_cfg_ready;
    int                                 pending_results;
    int                                 mismatches;

    int n_set = 0;
    int n_restore = 0;
    int n_tick = 0;
    int n_spare = 0;
    int n_setting = 0;
    int eager_left = 0;

    always #5 i_clk = ~i_clk;

    led_blink_pattern_engine #(.LED_COUNT(8)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_led_index    (i_led_index),
        .i_on_time      (i_on_time),
        .i_off_time     (i_off_time),
        .i_push_request (i_push_request),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted),
        .o_pin_levels   (o_pin_levels),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lbpe_pin_checker pin_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_led_index    (i_led_index),
        .i_on_time      (i_on_time),
        .i_off_time     (i_off_time),
        .i_push_request (i_push_request),
        .i_valid        (o_valid),
        .i_accepted     (o_accepted),
        .i_pin_levels   (o_pin_levels),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_run_done     (run_done),
        .o_pending      (pending_results),
        .o_mismatches   (mismatches)
    );

    // one item transfer; start stays high on return so a back-to-back item can follow
    task automatic send_item(input logic [1:0] func, input logic [lbpe_pkg::LIDX_W-1:0] idx,
                             input logic [lbpe_pkg::ON_W-1:0] on,
                             input logic [lbpe_pkg::OFF_W-1:0] off,
                             input logic push);
        int gap;
        if (eager_left > 0) begin
            eager_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                eager_left = $urandom_range(10, 40);
            gap = $urandom_range(0, 7);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_led_index    <= idx;
        i_on_time      <= on;
        i_off_time     <= off;
        i_push_request <= push;
        do @(posedge i_clk); while (busy);
        case (func)
            lbpe_pkg::FUNC_SET:     n_set++;
            lbpe_pkg::FUNC_RESTORE: n_restore++;
            lbpe_pkg::FUNC_TICK:    n_tick++;
            default:                n_spare++;
        endcase
    endtask

    // tick with random content in the ignored fields
    task automatic send_tick();
        send_item(lbpe_pkg::FUNC_TICK, lbpe_pkg::LIDX_W'($urandom),
                  lbpe_pkg::ON_W'($urandom), lbpe_pkg::OFF_W'($urandom), 1'($urandom));
    endtask

    // stop issuing and wait until every result has come back
    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        @(posedge i_clk);
    endtask

    // new mask setting, plus a write to an unused index
    task automatic set_masks(input logic [lbpe_pkg::PIN_W-1:0] led_bits,
                             input logic [lbpe_pkg::PIN_W-1:0] pol_bits);
        logic [1:0]                 idx_list [3];
        logic [lbpe_pkg::PIN_W-1:0] data_list [3];
        wait_idle();
        idx_list[0]  = $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
        data_list[0] = lbpe_pkg::PIN_W'($urandom);
        idx_list[1]  = lbpe_pkg::CFG_CONFIGURED;
        data_list[1] = led_bits;
        idx_list[2]  = lbpe_pkg::CFG_ACTIVE_HIGH;
        data_list[2] = pol_bits;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= data_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        n_setting++;
    endtask

    // mostly short times so timers expire often
    function automatic logic [lbpe_pkg::ON_W-1:0] pick_on();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lbpe_pkg::ON_W'($urandom);
            2:       return '1;
            default: return lbpe_pkg::ON_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [lbpe_pkg::OFF_W-1:0] pick_off();
        case ($urandom_range(0, 11))
            0:       return '0;
            1, 2:    return OFF_ONCE;
            3:       return {1'b1, 16'($urandom)};
            4:       return lbpe_pkg::OFF_W'($urandom);
            5:       return 17'h0FFFF;
            default: return lbpe_pkg::OFF_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic send_random();
        int         r;
        logic [1:0] func;
        r = $urandom_range(0, 99);
        if (r < 45)
            func = lbpe_pkg::FUNC_TICK;
        else if (r < 80)
            func = lbpe_pkg::FUNC_SET;
        else if (r < 94)
            func = lbpe_pkg::FUNC_RESTORE;
        else
            func = FUNC_SPARE;
        send_item(func, lbpe_pkg::LIDX_W'($urandom), pick_on(), pick_off(), 1'($urandom));
    endtask

    initial begin
        logic [lbpe_pkg::PIN_W-1:0] led_list [6];
        logic [lbpe_pkg::PIN_W-1:0] pol_list [6];
        int                         waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: led 7 left unconfigured, mixed polarity
        set_masks(8'h7F, 8'h0F);
        send_item(lbpe_pkg::FUNC_SET, 3'd0, 16'd0, 17'd5, 1'b0);           // steady dark
        send_item(lbpe_pkg::FUNC_SET, 3'd1, 16'd3, 17'd0, 1'b0);           // steady lit
        send_item(lbpe_pkg::FUNC_SET, 3'd2, 16'd2, 17'd3, 1'b0);           // plain blink
        send_item(lbpe_pkg::FUNC_SET, 3'd3, 16'd1, OFF_ONCE, 1'b0);        // one flash
        send_item(lbpe_pkg::FUNC_SET, 3'd4, 16'hFFFF, 17'h0FFFF, 1'b0);    // longest times
        send_item(lbpe_pkg::FUNC_SET, 3'd5, 16'd1, OFF_MOST_NEG, 1'b0);    // other negative
        send_item(lbpe_pkg::FUNC_SET, 3'd6, 16'd2, 17'd2, 1'b1);           // priority push
        send_item(lbpe_pkg::FUNC_SET, 3'd6, 16'd5, 17'd5, 1'b0);           // updates saved
        send_item(lbpe_pkg::FUNC_SET, 3'd7, 16'd3, 17'd3, 1'b1);           // unconfigured
        send_item(lbpe_pkg::FUNC_RESTORE, 3'd7, 16'd0, 17'd0, 1'b0);
        send_item(FUNC_SPARE, 3'd0, 16'hFFFF, OFF_ONCE, 1'b1);             // unused code
        repeat (4) send_tick();
        send_item(lbpe_pkg::FUNC_RESTORE, 3'd6, 16'd0, 17'd0, 1'b0);       // pop priority
        send_item(lbpe_pkg::FUNC_RESTORE, 3'd2, 16'd0, 17'd0, 1'b0);       // swap, none held
        send_item(lbpe_pkg::FUNC_SET, 3'd3, 16'd1, OFF_ONCE, 1'b1);
        repeat (6) send_tick();

        // random part over several mask settings, extremes among them
        led_list = '{8'hFF, 8'hFF, 8'h00, lbpe_pkg::PIN_W'($urandom),
                     lbpe_pkg::PIN_W'($urandom), 8'hFF};
        pol_list = '{8'hFF, 8'h00, lbpe_pkg::PIN_W'($urandom), lbpe_pkg::PIN_W'($urandom),
                     lbpe_pkg::PIN_W'($urandom), lbpe_pkg::PIN_W'($urandom)};
        for (int p = 0; p < 6; p++) begin
            set_masks(led_list[p], pol_list[p]);
            repeat (PHASE_ITEMS) send_random();
        end

        // drain, then allow for stray results
        start <= 1'b0;
        waited = 0;
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        run_done <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d set, %0d restore, %0d tick and %0d unused-code items",
                 n_set, n_restore, n_tick, n_spare);
        $display("across %0d mask settings, %0d mismatches", n_setting, mismatches);
        if (mismatches == 0) begin
            $display("led_blink_pattern_engine: match");
        end else begin
            $display("led_blink_pattern_engine: mismatch");
        end
        $finish;
    end

    // hang guard
    initial begin
        #3000000;
        $display("led_blink_pattern_engine: mismatch");
        $finish;
    end

endmodule
